// ===== rtl/core/threshold_blob_centroid_bbox_macros.svh =====
// Assertion macros used by the threshold/centroid block checker.
`ifndef THRESHOLD_BLOB_CENTROID_BBOX_MACROS_SVH
`define THRESHOLD_BLOB_CENTROID_BBOX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBCB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tbcb_pkg.sv =====
// Types, constants and helpers for the threshold/centroid/bounding-box block.
package tbcb_pkg;

    localparam int unsigned MAX_DIM = 1024;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned CNT_W   = 21;
    localparam int unsigned SUM_W   = 30;

    localparam int unsigned COORD_LIM =
        ((MAX_DIM - 1) > ((2 ** COORD_W) - 1)) ? ((2 ** COORD_W) - 1) : (MAX_DIM - 1);
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_LIM);

    localparam logic [PIX_W-1:0] THR_RESET = PIX_W'(30);
    localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(255);
    localparam logic [PIX_W-1:0] PIX_BLACK = '0;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int unsigned STEP_W    = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               frame_last;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   binary_pixel;
        logic               stats_valid;
        logic [CNT_W-1:0]   white_total;
        logic [CNT_W-1:0]   black_total;
        logic [COORD_W-1:0] centroid_x;
        logic [COORD_W-1:0] centroid_y;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_bottom;
        logic               no_white;
    } t_out_item;

    // Classified pixel as it travels from front to back; stats fields are
    // zero unless last is set.
    typedef struct packed {
        logic               white;
        logic               last;
        logic               no_white;
        logic [CNT_W-1:0]   white_total;
        logic [CNT_W-1:0]   black_total;
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_bottom;
    } t_rec;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

endpackage

// ===== rtl/core/tbcb_front.sv =====
// Front end: threshold register, pixel classification and frame accumulators.
module tbcb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tbcb_pkg::PIX_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  tbcb_pkg::t_in_item            i_item,
    output tbcb_pkg::t_rec                o_rec
);

    logic [tbcb_pkg::PIX_W-1:0]   r_thr;
    logic [tbcb_pkg::CNT_W-1:0]   r_wcnt, n_wcnt;
    logic [tbcb_pkg::CNT_W-1:0]   r_bcnt, n_bcnt;
    logic [tbcb_pkg::SUM_W-1:0]   r_sx, n_sx;
    logic [tbcb_pkg::SUM_W-1:0]   r_sy, n_sy;
    logic [tbcb_pkg::COORD_W-1:0] r_lx, n_lx, r_ly, n_ly, r_hx, n_hx, r_hy, n_hy;
    logic                         r_seen, n_seen;

    logic                         white;
    logic [tbcb_pkg::COORD_W-1:0] x, y;
    logic [tbcb_pkg::SUM_W:0]     add_x, add_y;

    assign o_cfg_ready = 1'b1;

    assign white = (i_item.pixel <= r_thr);
    assign x     = tbcb_pkg::clamp_coord(i_item.pos_x);
    assign y     = tbcb_pkg::clamp_coord(i_item.pos_y);
    assign add_x = {1'b0, r_sx} + (tbcb_pkg::SUM_W + 1)'(x);
    assign add_y = {1'b0, r_sy} + (tbcb_pkg::SUM_W + 1)'(y);

    always_comb begin
        n_wcnt = r_wcnt;
        n_bcnt = r_bcnt;
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_lx   = r_lx;
        n_ly   = r_ly;
        n_hx   = r_hx;
        n_hy   = r_hy;
        n_seen = r_seen;
        if (white) begin
            n_wcnt = (&r_wcnt) ? r_wcnt : r_wcnt + 1'b1;
            n_sx   = add_x[tbcb_pkg::SUM_W] ? '1 : add_x[tbcb_pkg::SUM_W-1:0];
            n_sy   = add_y[tbcb_pkg::SUM_W] ? '1 : add_y[tbcb_pkg::SUM_W-1:0];
            n_seen = 1'b1;
            if (!r_seen) begin
                n_lx = x;
                n_hx = x;
                n_ly = y;
                n_hy = y;
            end else begin
                if (x < r_lx) n_lx = x;
                if (x > r_hx) n_hx = x;
                if (y < r_ly) n_ly = y;
                if (y > r_hy) n_hy = y;
            end
        end else begin
            n_bcnt = (&r_bcnt) ? r_bcnt : r_bcnt + 1'b1;
        end
    end

    always_comb begin
        o_rec       = '0;
        o_rec.white = white;
        o_rec.last  = i_item.frame_last;
        if (i_item.frame_last) begin
            o_rec.no_white    = !n_seen;
            o_rec.white_total = n_wcnt;
            o_rec.black_total = n_bcnt;
            if (n_seen) begin
                o_rec.sum_x      = n_sx;
                o_rec.sum_y      = n_sy;
                o_rec.box_left   = n_lx;
                o_rec.box_top    = n_ly;
                o_rec.box_right  = n_hx;
                o_rec.box_bottom = n_hy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= tbcb_pkg::THR_RESET;
            r_wcnt <= '0;
            r_bcnt <= '0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_lx   <= '0;
            r_ly   <= '0;
            r_hx   <= '0;
            r_hy   <= '0;
            r_seen <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (i_accept) begin
                if (i_item.frame_last) begin
                    // frame closed: start the next one from nothing
                    r_wcnt <= '0;
                    r_bcnt <= '0;
                    r_sx   <= '0;
                    r_sy   <= '0;
                    r_lx   <= '0;
                    r_ly   <= '0;
                    r_hx   <= '0;
                    r_hy   <= '0;
                    r_seen <= 1'b0;
                end else begin
                    r_wcnt <= n_wcnt;
                    r_bcnt <= n_bcnt;
                    r_sx   <= n_sx;
                    r_sy   <= n_sy;
                    r_lx   <= n_lx;
                    r_ly   <= n_ly;
                    r_hx   <= n_hx;
                    r_hy   <= n_hy;
                    r_seen <= n_seen;
                end
            end
        end
    end

endmodule

// ===== rtl/core/tbcb_fifo.sv =====
// Short register queue carrying classified pixels from front to back.
module tbcb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  tbcb_pkg::t_rec i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output tbcb_pkg::t_rec o_rdata,
    output logic           o_empty
);

    tbcb_pkg::t_rec                 r_mem [tbcb_pkg::FIFO_DEPTH];
    logic [tbcb_pkg::FIFO_AW-1:0]   r_wp, r_rp;
    logic [tbcb_pkg::FIFO_CW-1:0]   r_cnt;
    logic                           do_wr, do_rd;

    assign o_full  = (r_cnt == tbcb_pkg::FIFO_CW'(tbcb_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) r_wp <= r_wp + 1'b1;
            if (do_rd) r_rp <= r_rp + 1'b1;
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/tbcb_back.sv =====
// Back end: serial centroid divider and result output register.
module tbcb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbcb_pkg::t_rec       i_rec,
    input  logic                 i_fifo_empty,
    output logic                 o_fifo_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tbcb_pkg::t_out_item  o_out
);

    tbcb_pkg::t_back_state        r_state, n_state;
    tbcb_pkg::t_rec               r_rec;
    logic [tbcb_pkg::SUM_W-1:0]   r_dx, r_dy;   // dividend in, quotient out
    logic [tbcb_pkg::CNT_W-1:0]   r_rx, r_ry;
    logic [tbcb_pkg::STEP_W-1:0]  r_step;
    tbcb_pkg::t_out_item          r_out;
    logic                         r_ov;

    logic                         slot_free, taken;
    logic                         start, direct_load, div_load;
    logic [tbcb_pkg::CNT_W:0]     shx, shy;
    logic                         gex, gey;
    logic [tbcb_pkg::CNT_W-1:0]   remx, remy;

    function automatic logic [tbcb_pkg::COORD_W-1:0] sat_q(
        input logic [tbcb_pkg::SUM_W-1:0] q);
        sat_q = (|q[tbcb_pkg::SUM_W-1:tbcb_pkg::COORD_W]) ? '1 : q[tbcb_pkg::COORD_W-1:0];
    endfunction

    function automatic tbcb_pkg::t_out_item build_out(
        input tbcb_pkg::t_rec             rec,
        input logic [tbcb_pkg::COORD_W-1:0] cx,
        input logic [tbcb_pkg::COORD_W-1:0] cy);
        tbcb_pkg::t_out_item o;
        o              = '0;
        o.binary_pixel = rec.white ? tbcb_pkg::PIX_WHITE : tbcb_pkg::PIX_BLACK;
        o.stats_valid  = rec.last;
        o.white_total  = rec.white_total;
        o.black_total  = rec.black_total;
        o.centroid_x   = cx;
        o.centroid_y   = cy;
        o.box_left     = rec.box_left;
        o.box_top      = rec.box_top;
        o.box_right    = rec.box_right;
        o.box_bottom   = rec.box_bottom;
        o.no_white     = rec.no_white;
        build_out      = o;
    endfunction

    assign o_empty   = !r_ov;
    assign o_out     = r_out;
    assign taken     = i_pop && r_ov;
    assign slot_free = !r_ov || taken;

    // one restoring step per cycle on both coordinates
    assign shx  = {r_rx, r_dx[tbcb_pkg::SUM_W-1]};
    assign shy  = {r_ry, r_dy[tbcb_pkg::SUM_W-1]};
    assign gex  = (shx >= {1'b0, r_rec.white_total});
    assign gey  = (shy >= {1'b0, r_rec.white_total});
    assign remx = gex ? tbcb_pkg::CNT_W'(shx - {1'b0, r_rec.white_total})
                      : shx[tbcb_pkg::CNT_W-1:0];
    assign remy = gey ? tbcb_pkg::CNT_W'(shy - {1'b0, r_rec.white_total})
                      : shy[tbcb_pkg::CNT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            tbcb_pkg::BK_IDLE: begin
                if (!i_fifo_empty && slot_free && i_rec.last && !i_rec.no_white)
                    n_state = tbcb_pkg::BK_DIV;
            end
            tbcb_pkg::BK_DIV: begin
                if (r_step == tbcb_pkg::STEP_LAST) n_state = tbcb_pkg::BK_DONE;
            end
            tbcb_pkg::BK_DONE: begin
                if (slot_free) n_state = tbcb_pkg::BK_IDLE;
            end
            default: n_state = tbcb_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_fifo_pop  = 1'b0;
        div_load    = 1'b0;
        case (r_state)
            tbcb_pkg::BK_IDLE: o_fifo_pop = !i_fifo_empty && slot_free;
            tbcb_pkg::BK_DONE: div_load   = slot_free;
            default: begin
                o_fifo_pop = 1'b0;
                div_load   = 1'b0;
            end
        endcase
        start       = o_fifo_pop && i_rec.last && !i_rec.no_white;
        direct_load = o_fifo_pop && !start;
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_rec <= i_rec;
            r_dx  <= i_rec.sum_x;
            r_dy  <= i_rec.sum_y;
            r_rx  <= '0;
            r_ry  <= '0;
        end else if (r_state == tbcb_pkg::BK_DIV) begin
            r_dx <= {r_dx[tbcb_pkg::SUM_W-2:0], gex};
            r_dy <= {r_dy[tbcb_pkg::SUM_W-2:0], gey};
            r_rx <= remx;
            r_ry <= remy;
        end
        if (direct_load) begin
            r_out <= build_out(i_rec, '0, '0);
        end else if (div_load) begin
            r_out <= build_out(r_rec, sat_q(r_dx), sat_q(r_dy));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbcb_pkg::BK_IDLE;
            r_step  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_step <= '0;
            end else if (r_state == tbcb_pkg::BK_DIV) begin
                r_step <= r_step + 1'b1;
            end
            if (direct_load || div_load) begin
                r_ov <= 1'b1;
            end else if (taken) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/threshold_blob_centroid_bbox.sv =====
// Binary threshold with per-frame white-pixel count, centroid and bounding box.
// Pixels are taken one per clock while full is low and each yields one result,
// registered in the queue and then in the output register. A pixel marked last
// of its frame carries the frame statistics; when the frame had white pixels
// its centroids come from a restoring divider in the back end before the result
// is loaded into the output register. In the meantime the four-entry queue
// between front and back keeps accepting pixels of the next frame until full
// rises. A frame with no white pixel sets no_white and reports zero centroid
// and box without any division.
// The threshold resets to 30 and is written through the cfg channel, which is
// always ready; write it only while the block holds no pixel in flight.
module threshold_blob_centroid_bbox (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  tbcb_pkg::t_in_item         i_in,
    output logic                       empty,
    input  logic                       pop,
    output tbcb_pkg::t_out_item        o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tbcb_pkg::PIX_W-1:0] i_cfg_data
);

    tbcb_pkg::t_rec wr_rec, rd_rec;
    logic           accept, fifo_empty, fifo_pop;

    assign accept = push && !full;

    tbcb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in),
        .o_rec       (wr_rec)
    );

    tbcb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (wr_rec),
        .o_full  (full),
        .i_rd    (fifo_pop),
        .o_rdata (rd_rec),
        .o_empty (fifo_empty)
    );

    tbcb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (rd_rec),
        .i_fifo_empty (fifo_empty),
        .o_fifo_pop   (fifo_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out        (o_out)
    );

endmodule

// ===== rtl/core/tbcb_checker.sv =====
// Port-level checker for the threshold/centroid block, bound to the top level.
`include "threshold_blob_centroid_bbox_macros.svh"

module tbcb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       empty,
    input  logic                       pop,
    input  tbcb_pkg::t_out_item        o_out
);

    `TBCB_ASSERT_NEXT(a_held, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_out), "result changed while not taken")

    `TBCB_ASSERT_NOW(a_plain_zero, i_clk, i_rst_n, !empty && !o_out.stats_valid,
        o_out.white_total == '0 && o_out.black_total == '0 && o_out.centroid_x == '0
            && o_out.box_right == '0 && !o_out.no_white,
        "stats fields set on an ordinary pixel")

    `TBCB_ASSERT_NOW(a_no_white, i_clk, i_rst_n,
        !empty && o_out.stats_valid && o_out.no_white,
        o_out.white_total == '0 && o_out.centroid_x == '0 && o_out.centroid_y == '0
            && o_out.box_right == '0 && o_out.box_bottom == '0,
        "empty frame reported white data")

    `TBCB_ASSERT_NOW(a_box_order, i_clk, i_rst_n,
        !empty && o_out.stats_valid && !o_out.no_white,
        o_out.box_left <= o_out.box_right && o_out.box_top <= o_out.box_bottom
            && o_out.white_total != '0
            && (o_out.binary_pixel == tbcb_pkg::PIX_WHITE
                || o_out.binary_pixel == tbcb_pkg::PIX_BLACK),
        "bounding box or count inconsistent")

endmodule

bind threshold_blob_centroid_bbox tbcb_checker u_tbcb_checker (.*);
